FILE: src/afem_pkg.sv
// Shared constants, widths, codes and state type of the admixture EM frequency update block.
package afem_pkg;

    // Store geometry.
    localparam int MAX_INDIVIDUALS = 256;
    localparam int MAX_SITES       = 1024;
    localparam int MAX_COMPONENTS  = 8;
    localparam int IND_W  = $clog2(MAX_INDIVIDUALS);
    localparam int SITE_W = $clog2(MAX_SITES);
    localparam int COMP_W = $clog2(MAX_COMPONENTS);
    localparam int GENO_AW = IND_W + SITE_W;
    localparam int PROP_AW = IND_W + COMP_W;
    localparam int FREQ_AW = SITE_W + COMP_W;

    // Configuration register widths.
    localparam int IT_W       = 10;
    localparam int EXCL_W     = 9;
    localparam int N_W        = 9;
    localparam int M_W        = 11;
    localparam int K_W        = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Arithmetic widths.
    localparam int Q_W     = 32;
    localparam int E_W     = 35;
    localparam int RECIP_W = 48;
    localparam int TERM_W  = 49;
    localparam int ACC_W   = 57;
    localparam int DEN_W   = 58;
    localparam int REM_W   = 59;
    localparam int STEP_W  = 6;

    localparam logic [Q_W-1:0]     ONE_Q31    = 32'h8000_0000;
    localparam logic [Q_W-1:0]     SMALL_X    = 32'h0000_8000;
    localparam logic [RECIP_W-1:0] RECIP_MAX  = {RECIP_W{1'b1}};
    localparam logic [STEP_W-1:0]  RECIP_STEPS = 6'd48;
    localparam logic [STEP_W-1:0]  FRAC_STEPS  = 6'd31;

    // Request codes.
    typedef logic [2:0] req_t;
    localparam req_t REQ_LOAD_GENO = 3'd0;
    localparam req_t REQ_LOAD_PROP = 3'd1;
    localparam req_t REQ_LOAD_FREQ = 3'd2;
    localparam req_t REQ_START     = 3'd3;
    localparam req_t REQ_READ      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ITER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SITES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPS = 3'd4;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P1_RD,
        ST_P1_MUL,
        ST_P1_ACC,
        ST_P1_CHK,
        ST_P1_DIVE,
        ST_P1_COMP,
        ST_P1_DIVC,
        ST_P1_WR,
        ST_P2_RDF,
        ST_P2_LDF,
        ST_P2_RD,
        ST_P2_M1,
        ST_P2_M2,
        ST_P2_M3,
        ST_P2_M4,
        ST_P2_M5,
        ST_P2_M6,
        ST_P2_M7,
        ST_P2_DIV,
        ST_P2_DIVW,
        ST_P2_WR,
        ST_DONE
    } em_state_t;

endpackage

FILE: src/afem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module afem_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/afem_div.sv
// Bit-serial restoring divider shared by the reciprocal and frequency quotients.
module afem_div
    import afem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [REM_W-1:0]     init_rem,
    input  logic [DEN_W-1:0]     divisor,
    input  logic [STEP_W-1:0]    steps,
    output logic                 done,
    output logic [RECIP_W-1:0]   quot
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [RECIP_W-1:0]  quot_reg;
    logic [REM_W-1:0]    shifted;
    logic [REM_W-1:0]    den_ext;
    logic                ge;

    // One quotient bit per cycle: shift, compare, subtract.
    assign shifted = {rem_reg[REM_W-2:0], 1'b0};
    assign den_ext = {1'b0, den_reg};
    assign ge      = shifted >= den_ext;

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= init_rem;
            den_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? (shifted - den_ext) : shifted;
            quot_reg <= {quot_reg[RECIP_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: src/admixture_freq_em_update.sv
// Top level: command port, stores, sequencer and datapath of the admixture EM frequency update.
// A load item may be followed by another in every cycle; busy stays low.
// A read item gives its answer strobe in the cycle after it is accepted, one read per cycle.
// A start item holds busy for the whole run, which uses the one shared multiplier, the bit-serial
// divider and one read per memory port.
// Reset returns the configuration registers to their defaults and the sequencer to idle.
// Stores are not cleared; results go out on a one-cycle strobe that the receiver cannot stall.
module admixture_freq_em_update
    import afem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [IND_W-1:0]      individual,
    input  logic [SITE_W-1:0]     site,
    input  logic [COMP_W-1:0]     component,
    input  logic [1:0]            genotype_count,
    input  logic [Q_W-1:0]        fraction_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic                  result_kind,
    output logic [Q_W-1:0]        frequency,
    output logic                  run_status
);

    // Configuration registers.
    logic [IT_W-1:0]   iter_reg;
    logic [EXCL_W-1:0] excl_reg;
    logic [N_W-1:0]    nind_reg;
    logic [M_W-1:0]    nsite_reg;
    logic [K_W-1:0]    ncomp_reg;

    // Sequencer and loop counters.
    em_state_t          state_reg, state_next;
    logic [IT_W-1:0]    it_reg;
    logic [IND_W-1:0]   i_reg;
    logic [SITE_W-1:0]  j_reg;
    logic [COMP_W-1:0]  k_reg;
    logic               halt_reg;
    logic               rd_pend_reg;

    // Datapath registers.
    logic [E_W-1:0]     e_reg;
    logic [Q_W-1:0]     prod_reg;
    logic [RECIP_W-1:0] hi_reg;
    logic [Q_W-1:0]     lo_reg;
    logic [ACC_W-1:0]   sa_reg;
    logic [ACC_W-1:0]   sb_reg;
    logic [Q_W-1:0]     f_reg;
    logic [RECIP_W-1:0] re_reg;
    logic [RECIP_W-1:0] rc_reg;
    logic [Q_W-1:0]     fnew_reg;

    // Memory read data.
    logic [1:0]         g_rd;
    logic [Q_W-1:0]     q_rd;
    logic [Q_W-1:0]     f_rd;
    logic [RECIP_W-1:0] re_rd;
    logic [RECIP_W-1:0] rc_rd;

    logic               acc;
    logic [N_W-1:0]     n_cap;
    logic [M_W-1:0]     m_cap;
    logic [K_W-1:0]     k_cap;
    logic               last_i, last_j, last_k, last_it, excl_hit;
    logic               e_bad, e_small, c_small, tot_zero, sa_ge;
    logic [Q_W-1:0]     c_val;
    logic [DEN_W-1:0]   tot;
    logic [RECIP_W-1:0] term;
    logic [TERM_W-1:0]  wa, wb;
    logic [Q_W-1:0]     mul_a, mul_b;
    logic [2*Q_W-1:0]   mul_p;
    logic [1:0]         g_clamp;
    logic [Q_W-1:0]     v_clamp;
    logic               div_start, div_done;
    logic [REM_W-1:0]   div_rem;
    logic [DEN_W-1:0]   div_den;
    logic [STEP_W-1:0]  div_steps;
    logic [RECIP_W-1:0] div_quot;
    logic               f_we;
    logic [FREQ_AW-1:0] f_waddr, f_raddr;
    logic [Q_W-1:0]     f_wdata;
    logic               zero_work, zero_halt;

    assign acc  = start && !busy;
    assign busy = (state_reg != ST_IDLE);

    // Load value clamping.
    assign g_clamp = (genotype_count == 2'd3) ? 2'd2 : genotype_count;
    assign v_clamp = (fraction_value > ONE_Q31) ? ONE_Q31 : fraction_value;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg  <= IT_W'(1);
            excl_reg  <= EXCL_W'(MAX_INDIVIDUALS);
            nind_reg  <= N_W'(MAX_INDIVIDUALS);
            nsite_reg <= M_W'(MAX_SITES);
            ncomp_reg <= K_W'(MAX_COMPONENTS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ITER:  iter_reg  <= cfg_data[IT_W-1:0];
                CFG_EXCL:  excl_reg  <= cfg_data[EXCL_W-1:0];
                CFG_INDS:  nind_reg  <= cfg_data[N_W-1:0];
                CFG_SITES: nsite_reg <= cfg_data[M_W-1:0];
                CFG_COMPS: ncomp_reg <= cfg_data[K_W-1:0];
                default:   ;
            endcase
        end
    end

    // Loop bounds capped to the store sizes, and loop-end flags.
    assign n_cap = (nind_reg > N_W'(MAX_INDIVIDUALS)) ? N_W'(MAX_INDIVIDUALS) : nind_reg;
    assign m_cap = (nsite_reg > M_W'(MAX_SITES)) ? M_W'(MAX_SITES) : nsite_reg;
    assign k_cap = (ncomp_reg > K_W'(MAX_COMPONENTS)) ? K_W'(MAX_COMPONENTS) : ncomp_reg;

    assign last_i   = (N_W'(i_reg) + 1'b1) == n_cap;
    assign last_j   = (M_W'(j_reg) + 1'b1) == m_cap;
    assign last_k   = (K_W'(k_reg) + 1'b1) == k_cap;
    assign last_it  = (it_reg + 1'b1) == iter_reg;
    assign excl_hit = N_W'(i_reg) == excl_reg;

    // Runs that need no loop work finish at once.
    assign zero_work = (iter_reg == '0) || (m_cap == '0) || (k_cap == '0) || (n_cap == '0);
    assign zero_halt = !((iter_reg == '0) || (m_cap == '0)) &&
                       ((k_cap == '0) ? (n_cap != '0) : 1'b1);

    // Expected frequency checks and complement.
    assign e_bad   = (e_reg == '0) || (e_reg >= E_W'(ONE_Q31));
    assign e_small = e_reg <= E_W'(SMALL_X);
    assign c_val   = ONE_Q31 - e_reg[Q_W-1:0];
    assign c_small = c_val <= SMALL_X;

    // Frequency quotient checks.
    assign tot      = DEN_W'(sa_reg) + DEN_W'(sb_reg);
    assign tot_zero = (tot == '0);
    assign sa_ge    = DEN_W'(sa_reg) >= tot;

    // Genotype-weighted terms.
    assign term = hi_reg + RECIP_W'(lo_reg);
    always_comb
    begin
        case (g_rd)
            2'd0:    begin wa = '0;                  wb = {term, 1'b0};      end
            2'd1:    begin wa = TERM_W'(term);       wb = TERM_W'(term);     end
            2'd2:    begin wa = {term, 1'b0};        wb = '0;                end
            default: begin wa = {term, 1'b0};        wb = '0;                end
        endcase
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            ST_P1_MUL: begin mul_a = f_rd;              mul_b = q_rd;                   end
            ST_P2_M1:  begin mul_a = f_reg;             mul_b = q_rd;                   end
            ST_P2_M2:  begin mul_a = prod_reg;          mul_b = Q_W'(re_rd[RECIP_W-1:Q_W]); end
            ST_P2_M3:  begin mul_a = prod_reg;          mul_b = re_rd[Q_W-1:0];         end
            ST_P2_M4:  begin mul_a = ONE_Q31 - f_reg;   mul_b = q_rd;                   end
            ST_P2_M5:  begin mul_a = prod_reg;          mul_b = Q_W'(rc_rd[RECIP_W-1:Q_W]); end
            ST_P2_M6:  begin mul_a = prod_reg;          mul_b = rc_rd[Q_W-1:0];         end
            default:   begin mul_a = '0;                mul_b = '0;                     end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Next-state logic and divider launch.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_rem    = '0;
        div_den    = '0;
        div_steps  = RECIP_STEPS;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && (req_type == REQ_START))
                begin
                    state_next = zero_work ? ST_DONE : ST_P1_RD;
                end
            end
            ST_P1_RD:  state_next = ST_P1_MUL;
            ST_P1_MUL: state_next = ST_P1_ACC;
            ST_P1_ACC: state_next = last_k ? ST_P1_CHK : ST_P1_RD;
            ST_P1_CHK:
            begin
                if (e_bad)
                begin
                    state_next = ST_DONE;
                end
                else if (e_small)
                begin
                    state_next = ST_P1_COMP;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_rem    = REM_W'(SMALL_X);
                    div_den    = DEN_W'(e_reg);
                    state_next = ST_P1_DIVE;
                end
            end
            ST_P1_DIVE: state_next = div_done ? ST_P1_COMP : ST_P1_DIVE;
            ST_P1_COMP:
            begin
                if (c_small)
                begin
                    state_next = ST_P1_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_rem    = REM_W'(SMALL_X);
                    div_den    = DEN_W'(c_val);
                    state_next = ST_P1_DIVC;
                end
            end
            ST_P1_DIVC: state_next = div_done ? ST_P1_WR : ST_P1_DIVC;
            ST_P1_WR:   state_next = (last_j && last_i) ? ST_P2_RDF : ST_P1_RD;
            ST_P2_RDF:  state_next = ST_P2_LDF;
            ST_P2_LDF:  state_next = ST_P2_RD;
            ST_P2_RD:
            begin
                if (!excl_hit)
                begin
                    state_next = ST_P2_M1;
                end
                else if (last_i)
                begin
                    state_next = ST_P2_DIV;
                end
            end
            ST_P2_M1: state_next = ST_P2_M2;
            ST_P2_M2: state_next = ST_P2_M3;
            ST_P2_M3: state_next = ST_P2_M4;
            ST_P2_M4: state_next = ST_P2_M5;
            ST_P2_M5: state_next = ST_P2_M6;
            ST_P2_M6: state_next = ST_P2_M7;
            ST_P2_M7: state_next = last_i ? ST_P2_DIV : ST_P2_RD;
            ST_P2_DIV:
            begin
                if (tot_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (sa_ge)
                begin
                    state_next = ST_P2_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_rem    = REM_W'(sa_reg);
                    div_den    = tot;
                    div_steps  = FRAC_STEPS;
                    state_next = ST_P2_DIVW;
                end
            end
            ST_P2_DIVW: state_next = div_done ? ST_P2_WR : ST_P2_DIVW;
            ST_P2_WR:
            begin
                if (last_k && last_j && last_it)
                begin
                    state_next = ST_DONE;
                end
                else if (last_k && last_j)
                begin
                    state_next = ST_P1_RD;
                end
                else
                begin
                    state_next = ST_P2_RDF;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Loop counters, halt flag and read-answer flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            halt_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= acc && (req_type == REQ_READ);
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc && (req_type == REQ_START))
                    begin
                        it_reg   <= '0;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        k_reg    <= '0;
                        halt_reg <= zero_work ? zero_halt : 1'b0;
                    end
                end
                ST_P1_ACC:
                begin
                    if (!last_k)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_P1_CHK:
                begin
                    if (e_bad)
                    begin
                        halt_reg <= 1'b1;
                    end
                end
                ST_P1_WR:
                begin
                    k_reg <= '0;
                    if (last_j)
                    begin
                        j_reg <= '0;
                        if (!last_i)
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_P2_RDF: i_reg <= '0;
                ST_P2_RD:
                begin
                    if (excl_hit && !last_i)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_P2_M7:
                begin
                    if (!last_i)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_P2_DIV:
                begin
                    if (tot_zero)
                    begin
                        halt_reg <= 1'b1;
                    end
                end
                ST_P2_WR:
                begin
                    if (last_k)
                    begin
                        k_reg <= '0;
                        if (last_j)
                        begin
                            j_reg <= '0;
                            i_reg <= '0;
                            if (!last_it)
                            begin
                                it_reg <= it_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Arithmetic datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:    e_reg <= '0;
            ST_P1_MUL:  prod_reg <= mul_p[2*Q_W-2:Q_W-1];
            ST_P1_ACC:  e_reg <= e_reg + E_W'(prod_reg);
            ST_P1_CHK:
            begin
                if (e_small)
                begin
                    re_reg <= RECIP_MAX;
                end
            end
            ST_P1_DIVE:
            begin
                if (div_done)
                begin
                    re_reg <= div_quot;
                end
            end
            ST_P1_COMP:
            begin
                if (c_small)
                begin
                    rc_reg <= RECIP_MAX;
                end
            end
            ST_P1_DIVC:
            begin
                if (div_done)
                begin
                    rc_reg <= div_quot;
                end
            end
            ST_P1_WR:   e_reg <= '0;
            ST_P2_LDF:
            begin
                f_reg  <= f_rd;
                sa_reg <= '0;
                sb_reg <= '0;
            end
            ST_P2_M1:   prod_reg <= mul_p[2*Q_W-2:Q_W-1];
            ST_P2_M2:   hi_reg <= mul_p[RECIP_W-1:0];
            ST_P2_M3:   lo_reg <= mul_p[2*Q_W-1:Q_W];
            ST_P2_M4:
            begin
                sa_reg   <= sa_reg + ACC_W'(wa);
                prod_reg <= mul_p[2*Q_W-2:Q_W-1];
            end
            ST_P2_M5:   hi_reg <= mul_p[RECIP_W-1:0];
            ST_P2_M6:   lo_reg <= mul_p[2*Q_W-1:Q_W];
            ST_P2_M7:   sb_reg <= sb_reg + ACC_W'(wb);
            ST_P2_DIV:
            begin
                if (sa_ge)
                begin
                    fnew_reg <= ONE_Q31;
                end
            end
            ST_P2_DIVW:
            begin
                if (div_done)
                begin
                    fnew_reg <= div_quot[Q_W-1:0];
                end
            end
            ST_P2_WR:   e_reg <= '0;
            default:    ;
        endcase
    end

    // Shared divider.
    afem_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .init_rem (div_rem),
        .divisor  (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Genotype store.
    afem_ram #(.AW(GENO_AW), .DW(2)) u_geno (
        .clk   (clk),
        .we    (acc && (req_type == REQ_LOAD_GENO)),
        .waddr ({individual, site}),
        .wdata (g_clamp),
        .raddr ({i_reg, j_reg}),
        .rdata (g_rd)
    );

    // Ancestry proportion store.
    afem_ram #(.AW(PROP_AW), .DW(Q_W)) u_prop (
        .clk   (clk),
        .we    (acc && (req_type == REQ_LOAD_PROP)),
        .waddr ({individual, component}),
        .wdata (v_clamp),
        .raddr ({i_reg, k_reg}),
        .rdata (q_rd)
    );

    // Frequency store: loads and reads when idle, updates during a run.
    assign f_we    = (acc && (req_type == REQ_LOAD_FREQ)) || (state_reg == ST_P2_WR);
    assign f_waddr = (state_reg == ST_P2_WR) ? {j_reg, k_reg} : {site, component};
    assign f_wdata = (state_reg == ST_P2_WR) ? fnew_reg : v_clamp;
    assign f_raddr = (state_reg == ST_IDLE) ? {site, component} : {j_reg, k_reg};

    afem_ram #(.AW(FREQ_AW), .DW(Q_W)) u_freq (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rd)
    );

    // Reciprocal stores.
    afem_ram #(.AW(GENO_AW), .DW(RECIP_W)) u_recip_e (
        .clk   (clk),
        .we    (state_reg == ST_P1_WR),
        .waddr ({i_reg, j_reg}),
        .wdata (re_reg),
        .raddr ({i_reg, j_reg}),
        .rdata (re_rd)
    );

    afem_ram #(.AW(GENO_AW), .DW(RECIP_W)) u_recip_c (
        .clk   (clk),
        .we    (state_reg == ST_P1_WR),
        .waddr ({i_reg, j_reg}),
        .wdata (rc_reg),
        .raddr ({i_reg, j_reg}),
        .rdata (rc_rd)
    );

    // Result strobe: a read answer or the run status.
    assign result_valid = rd_pend_reg || (state_reg == ST_DONE);
    assign result_kind  = (state_reg == ST_DONE);
    assign frequency    = rd_pend_reg ? f_rd : '0;
    assign run_status   = (state_reg == ST_DONE) && halt_reg;

endmodule

FILE: src/afem_chk.sv
// Port-level checker for the admixture EM frequency update, bound to the top level.
module afem_chk
    import afem_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic [2:0]     req_type,
    input logic           result_valid,
    input logic           result_kind,
    input logic [Q_W-1:0] frequency,
    input logic           run_status
);

    // An accepted read is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_READ)) |=> (result_valid && !result_kind))
    else $error("read item not answered in the next cycle");

    // An accepted start makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_START)) |=> busy)
    else $error("start item did not raise busy");

    // A status result carries no frequency and ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind) |-> (frequency == '0))
    else $error("status result with nonzero frequency");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind) |=> !busy)
    else $error("block still busy after its status result");

    // A read answer never reports a halt.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_kind) |-> !run_status)
    else $error("read answer with halt status");

endmodule

bind admixture_freq_em_update afem_chk u_afem_chk (.*);
